FILE: src/ahbd_pkg.sv
// Shared types, constants and arithmetic helpers for the heater burst driver.
package ahbd_pkg;

	localparam int SAMPLE_W   = 10;
	localparam int TICK_W     = 16;
	localparam int DUTY_W     = 8;
	localparam int DUTY_SAT_W = 7;
	localparam int PROD_W     = TICK_W + DUTY_SAT_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [DUTY_SAT_W-1:0] DUTY_MAX = 7'd100;

	localparam logic [SAMPLE_W-1:0] ZERO_OFFSET_RST  = 10'd419;
	localparam logic [SAMPLE_W-1:0] CURRENT_BAND_RST = 10'd2;
	localparam logic [TICK_W-1:0]   CYCLE_TICKS_RST  = 16'd16383;

	// floor(y / 25) = (y * RECIP_25) >> 26 holds for y below 2^21
	localparam logic [21:0] RECIP_25   = 22'd2684355;
	// floor(d / 10) = (d * RECIP_10) >> 11 holds for d up to 100
	localparam logic [7:0]  RECIP_10   = 8'd205;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ZERO_OFFSET  = 2'd0,
		CFG_CURRENT_BAND = 2'd1,
		CFG_CYCLE_TICKS  = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_WAIT = 2'd1,
		PH_RUN  = 2'd2
	} phase_t;

	typedef struct packed {
		logic                  start_req;
		logic                  full_cycle_mode;
		logic [DUTY_SAT_W-1:0] duty_sat;
		logic [SAMPLE_W-1:0]   current_sample;
		logic [PROD_W-1:0]     on_prod;
	} item_t;

	// Divide the product cycle_ticks * duty by 100: drop two bits, then divide by 25.
	function automatic logic [TICK_W-1:0] div100(input logic [PROD_W-1:0] x);
		logic [20:0] y;
		logic [42:0] p;
		y = x[PROD_W-1:2];
		p = {22'd0, y} * {21'd0, RECIP_25};
		return p[41:26];
	endfunction

	// Whole tens of a saturated duty.
	function automatic logic [3:0] div10(input logic [DUTY_SAT_W-1:0] d);
		logic [14:0] p;
		p = {8'd0, d} * {7'd0, RECIP_10};
		return p[14:11];
	endfunction

endpackage

FILE: src/ahbd_in_stage.sv
// Input register: captures one tick beat, saturates duty and forms cycle_ticks * duty.
module ahbd_in_stage (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic                         start_req,
	input  logic                         full_cycle_mode,
	input  logic [ahbd_pkg::DUTY_W-1:0]  duty_percent,
	input  logic [ahbd_pkg::SAMPLE_W-1:0] current_sample,
	input  logic [ahbd_pkg::TICK_W-1:0]  per,
	input  logic                         advance,
	output logic                         valid_s1,
	output ahbd_pkg::item_t              item_s1
);

	logic [ahbd_pkg::DUTY_SAT_W-1:0] duty_sat;
	logic [ahbd_pkg::PROD_W-1:0]     prod;
	logic                            load;

	assign item_stall = valid_s1 && !advance;
	assign load       = item_valid && !item_stall;

	always_comb begin
		if (duty_percent > {1'b0, ahbd_pkg::DUTY_MAX}) begin
			duty_sat = ahbd_pkg::DUTY_MAX;
		end else begin
			duty_sat = duty_percent[ahbd_pkg::DUTY_SAT_W-1:0];
		end
		prod = {{ahbd_pkg::DUTY_SAT_W{1'b0}}, per} * {{ahbd_pkg::TICK_W{1'b0}}, duty_sat};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.start_req       <= start_req;
			item_s1.full_cycle_mode <= full_cycle_mode;
			item_s1.duty_sat        <= duty_sat;
			item_s1.current_sample  <= current_sample;
			item_s1.on_prod         <= prod;
		end
	end

endmodule

FILE: src/ahbd_ctrl.sv
// Burst sequencer: phase state, tick and cycle counters, and the result register.
module ahbd_ctrl #(
	parameter int CYCLES_PER_BURST = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s1,
	input  ahbd_pkg::item_t               item_s1,
	input  logic                          advance,
	input  logic [ahbd_pkg::SAMPLE_W-1:0] zero_offset,
	input  logic [ahbd_pkg::SAMPLE_W-1:0] current_band,
	input  logic [ahbd_pkg::TICK_W-1:0]   per,
	output logic                          res_valid,
	output logic                          heater_on,
	output logic                          busy_res,
	output logic                          burst_done
);

	localparam int CW = $clog2(CYCLES_PER_BURST + 1);
	localparam logic [CW:0] CYC_LAST = (CW + 1)'(CYCLES_PER_BURST);
	localparam logic [3:0]  CYC_SAT  = 4'(CYCLES_PER_BURST);

	ahbd_pkg::phase_t              phase_q, phase_n;
	logic [ahbd_pkg::TICK_W-1:0]   tick_q, tick_n;
	logic [CW-1:0]                 cyc_q, cyc_n;
	logic [CW-1:0]                 on_cyc_q, on_cyc_n;
	logic [ahbd_pkg::TICK_W-1:0]   on_tick_q, on_tick_n;
	logic                          dimmer_q, dimmer_n;
	logic                          drive_q, drive_n;
	logic                          heat, busy, done;
	logic [ahbd_pkg::SAMPLE_W-1:0] offset_abs;
	logic                          flows;
	logic [3:0]                    tens;
	logic                          step;

	assign step = advance && valid_s1;

	always_comb begin
		if (item_s1.current_sample >= zero_offset) begin
			offset_abs = item_s1.current_sample - zero_offset;
		end else begin
			offset_abs = zero_offset - item_s1.current_sample;
		end
		flows = offset_abs > current_band;
		tens  = ahbd_pkg::div10(item_s1.duty_sat);
	end

	always_comb begin
		phase_n   = phase_q;
		tick_n    = tick_q;
		cyc_n     = cyc_q;
		on_cyc_n  = on_cyc_q;
		on_tick_n = on_tick_q;
		dimmer_n  = dimmer_q;
		drive_n   = drive_q;
		heat      = drive_q;
		busy      = 1'b0;
		done      = 1'b0;
		unique case (phase_q)
			ahbd_pkg::PH_IDLE: begin
				if (item_s1.start_req) begin
					if (item_s1.duty_sat == '0) begin
						drive_n = 1'b0;
						heat    = 1'b0;
						done    = 1'b1;
					end else begin
						dimmer_n  = !item_s1.full_cycle_mode;
						on_cyc_n  = (tens > CYC_SAT) ? CYC_SAT[CW-1:0] : tens[CW-1:0];
						on_tick_n = ahbd_pkg::div100(item_s1.on_prod);
						tick_n    = '0;
						cyc_n     = '0;
						busy      = 1'b1;
						phase_n   = flows ? ahbd_pkg::PH_RUN : ahbd_pkg::PH_WAIT;
					end
				end
			end
			ahbd_pkg::PH_WAIT: begin
				busy = 1'b1;
				if (flows) begin
					tick_n  = '0;
					cyc_n   = '0;
					phase_n = ahbd_pkg::PH_RUN;
				end
			end
			ahbd_pkg::PH_RUN: begin
				busy    = 1'b1;
				heat    = dimmer_q ? (tick_q < on_tick_q) : (cyc_q < on_cyc_q);
				drive_n = heat;
				if (({1'b0, tick_q} + 17'd1) >= {1'b0, per}) begin
					tick_n = '0;
					if (({1'b0, cyc_q} + (CW + 1)'(1)) >= CYC_LAST) begin
						cyc_n   = '0;
						done    = 1'b1;
						phase_n = ahbd_pkg::PH_IDLE;
						if (dimmer_q) begin
							drive_n = 1'b0;
						end
					end else begin
						cyc_n = cyc_q + CW'(1);
					end
				end else begin
					tick_n = tick_q + 16'd1;
				end
			end
			default: begin
				phase_n = ahbd_pkg::PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ahbd_pkg::PH_IDLE;
			tick_q    <= '0;
			cyc_q     <= '0;
			on_cyc_q  <= '0;
			on_tick_q <= '0;
			dimmer_q  <= 1'b0;
			drive_q   <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_n;
			tick_q    <= tick_n;
			cyc_q     <= cyc_n;
			on_cyc_q  <= on_cyc_n;
			on_tick_q <= on_tick_n;
			dimmer_q  <= dimmer_n;
			drive_q   <= drive_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance) begin
			res_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			heater_on  <= heat;
			busy_res   <= busy;
			burst_done <= done;
		end
	end

endmodule

FILE: src/ac_heater_burst_driver_unit.sv
// Top level of the burst-fire heater driver: configuration registers and pipeline glue.
//
//  channel   direction  handshake                fields
//  item      in         item_valid / item_stall  start_req full_cycle_mode duty_percent
//                                                current_sample
//  result    out        res_valid / res_stall    heater_on busy_res burst_done
//  config    in         cfg_we                   cfg_index cfg_wdata
//
// One tick beat enters per clock while the result channel does not stall; its result
// leaves through the input register and then the result register.
// The tick beat is registered with cycle_ticks * duty already formed; the sequencer
// then divides by 100 and steps the counters in one pass before the result register.
// Reset clears the sequencer to idle with the heater off and loads the register defaults.
// A stalled result holds the result register and backs up into the input register;
// item_stall rises only when both stages are full.
module ac_heater_burst_driver_unit #(
	parameter int CYCLES_PER_BURST = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic                            start_req,
	input  logic                            full_cycle_mode,
	input  logic [ahbd_pkg::DUTY_W-1:0]     duty_percent,
	input  logic [ahbd_pkg::SAMPLE_W-1:0]   current_sample,
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic                            heater_on,
	output logic                            busy_res,
	output logic                            burst_done,
	input  logic                            cfg_we,
	input  logic [ahbd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ahbd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	logic [ahbd_pkg::SAMPLE_W-1:0] zero_offset_q;
	logic [ahbd_pkg::SAMPLE_W-1:0] current_band_q;
	logic [ahbd_pkg::TICK_W-1:0]   cycle_ticks_q;
	logic [ahbd_pkg::TICK_W-1:0]   per;
	logic                          advance;
	logic                          valid_s1;
	ahbd_pkg::item_t               item_s1;

	// Register writes; an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_offset_q  <= ahbd_pkg::ZERO_OFFSET_RST;
			current_band_q <= ahbd_pkg::CURRENT_BAND_RST;
			cycle_ticks_q  <= ahbd_pkg::CYCLE_TICKS_RST;
		end else if (cfg_we) begin
			unique case (ahbd_pkg::cfg_idx_t'(cfg_index))
				ahbd_pkg::CFG_ZERO_OFFSET:  zero_offset_q  <= cfg_wdata[ahbd_pkg::SAMPLE_W-1:0];
				ahbd_pkg::CFG_CURRENT_BAND: current_band_q <= cfg_wdata[ahbd_pkg::SAMPLE_W-1:0];
				ahbd_pkg::CFG_CYCLE_TICKS:  cycle_ticks_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// A zero cycle length behaves as one tick.
	assign per = (cycle_ticks_q == '0) ? 16'd1 : cycle_ticks_q;

	// Advance whenever the result register is empty or its beat is taken.
	assign advance = !res_valid || !res_stall;

	ahbd_in_stage u_in (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.start_req       (start_req),
		.full_cycle_mode (full_cycle_mode),
		.duty_percent    (duty_percent),
		.current_sample  (current_sample),
		.per             (per),
		.advance         (advance),
		.valid_s1        (valid_s1),
		.item_s1         (item_s1)
	);

	ahbd_ctrl #(
		.CYCLES_PER_BURST (CYCLES_PER_BURST)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1),
		.advance      (advance),
		.zero_offset  (zero_offset_q),
		.current_band (current_band_q),
		.per          (per),
		.res_valid    (res_valid),
		.heater_on    (heater_on),
		.busy_res     (busy_res),
		.burst_done   (burst_done)
	);

endmodule

FILE: sim/heater_tick_checker.sv
// Scoreboard for the heater burst driver: predicts every result beat and compares it.
module heater_tick_checker #(
	parameter int BURST_CYCLES = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	input  logic                            item_stall,
	input  logic                            start_req,
	input  logic                            full_cycle_mode,
	input  logic [ahbd_pkg::DUTY_W-1:0]     duty_percent,
	input  logic [ahbd_pkg::SAMPLE_W-1:0]   current_sample,
	input  logic                            res_valid,
	input  logic                            res_stall,
	input  logic                            heater_on,
	input  logic                            busy_res,
	input  logic                            burst_done,
	input  logic                            cfg_we,
	input  logic [ahbd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ahbd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                              fault_cnt,
	output int                              open_cnt,
	output int                              checked_cnt,
	output int                              done_cnt
);
	import ahbd_pkg::*;

	typedef struct packed {
		logic heat;
		logic busy;
		logic done;
	} drive_beat_t;

	logic [SAMPLE_W-1:0] zero_cfg;
	logic [SAMPLE_W-1:0] band_cfg;
	logic [TICK_W-1:0]   period_cfg;
	phase_t              burst_phase;
	logic [TICK_W-1:0]   tick_pos;
	logic [TICK_W-1:0]   on_ticks;
	logic [3:0]          cycle_pos;
	logic [3:0]          on_cycles;
	logic                dimmer;
	logic                drive;
	drive_beat_t         drive_q[$];
	int                  faults;
	int                  checked;
	int                  dones;

	function automatic logic current_present(input logic [SAMPLE_W-1:0] s);
		logic [SAMPLE_W-1:0] offset_abs;
		offset_abs = (s >= zero_cfg) ? s - zero_cfg : zero_cfg - s;
		return offset_abs > band_cfg;
	endfunction

	// Step the burst sequencer by one tick and return the levels it shows.
	function automatic drive_beat_t advance_burst(input logic start, input logic full,
			input logic [DUTY_W-1:0] duty_in, input logic [SAMPLE_W-1:0] s);
		drive_beat_t             r;
		logic [DUTY_SAT_W-1:0]   duty;
		logic [TICK_W-1:0]       period;
		logic [PROD_W-1:0]       on_prod;
		int                      tens;
		duty = (duty_in > 8'd100) ? DUTY_MAX : duty_in[DUTY_SAT_W-1:0];
		period = (period_cfg == '0) ? 16'd1 : period_cfg;
		r.heat = drive;
		r.busy = 1'b0;
		r.done = 1'b0;
		unique case (burst_phase)
		PH_IDLE: begin
			if (start && duty == '0) begin
				drive = 1'b0;
				r.heat = 1'b0;
				r.done = 1'b1;
			end else if (start) begin
				dimmer = !full;
				tens = duty / 10;
				if (tens > BURST_CYCLES) tens = BURST_CYCLES;
				on_cycles = 4'(tens);
				on_prod = period * duty;
				on_ticks = 16'(on_prod / 23'd100);
				tick_pos = '0;
				cycle_pos = '0;
				r.busy = 1'b1;
				if (current_present(s)) burst_phase = PH_RUN;
				else burst_phase = PH_WAIT;
			end
		end
		PH_WAIT: begin
			r.busy = 1'b1;
			if (current_present(s)) begin
				tick_pos = '0;
				cycle_pos = '0;
				burst_phase = PH_RUN;
			end
		end
		PH_RUN: begin
			r.busy = 1'b1;
			r.heat = dimmer ? (tick_pos < on_ticks) : (cycle_pos < on_cycles);
			drive = r.heat;
			if ({1'b0, tick_pos} + 17'd1 >= {1'b0, period}) begin
				tick_pos = '0;
				if (int'(cycle_pos) + 1 >= BURST_CYCLES) begin
					cycle_pos = '0;
					r.done = 1'b1;
					burst_phase = PH_IDLE;
					if (dimmer) drive = 1'b0;
				end else begin
					cycle_pos = cycle_pos + 4'd1;
				end
			end else begin
				tick_pos = tick_pos + 16'd1;
			end
		end
		default: burst_phase = PH_IDLE;
		endcase
		return r;
	endfunction

	task automatic report_fault(input string msg);
		faults++;
		if (faults <= 10) $display("mismatch: %s", msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		drive_beat_t got;
		drive_beat_t want;
		if (!arst_n) begin
			zero_cfg = ZERO_OFFSET_RST;
			band_cfg = CURRENT_BAND_RST;
			period_cfg = CYCLE_TICKS_RST;
			burst_phase = PH_IDLE;
			tick_pos = '0;
			on_ticks = '0;
			cycle_pos = '0;
			on_cycles = '0;
			dimmer = 1'b0;
			drive = 1'b0;
			drive_q.delete();
			faults = 0;
			checked = 0;
			dones = 0;
		end else begin
			// pop before push: a result never belongs to a tick taken on the same edge
			if (res_valid && !res_stall) begin
				got = {heater_on, busy_res, burst_done};
				if (drive_q.size() == 0) begin
					report_fault($sformatf("result beat %0d with no tick pending: heat=%b busy=%b done=%b",
						checked, heater_on, busy_res, burst_done));
				end else begin
					want = drive_q.pop_front();
					if (got !== want)
						report_fault($sformatf("result beat %0d: wanted heat=%b busy=%b done=%b, got heat=%b busy=%b done=%b",
							checked, want.heat, want.busy, want.done,
							heater_on, busy_res, burst_done));
				end
				checked++;
				if (burst_done === 1'b1) dones++;
			end
			if (item_valid && !item_stall)
				drive_q.push_back(advance_burst(start_req, full_cycle_mode, duty_percent,
					current_sample));
			if (cfg_we) begin
				unique case (cfg_index)
				CFG_ZERO_OFFSET:  zero_cfg = cfg_wdata[SAMPLE_W-1:0];
				CFG_CURRENT_BAND: band_cfg = cfg_wdata[SAMPLE_W-1:0];
				CFG_CYCLE_TICKS:  period_cfg = cfg_wdata[TICK_W-1:0];
				default: ;
				endcase
			end
		end
		fault_cnt <= faults;
		open_cnt <= drive_q.size();
		checked_cnt <= checked;
		done_cnt <= dones;
	end

endmodule

FILE: sim/tb_ac_heater_burst_driver_unit.sv
// Testbench top for the heater burst driver: clock, reset, tick stimulus, receiver and verdict.
module tb_ac_heater_burst_driver_unit;
	import ahbd_pkg::*;

	localparam int BURST_CYCLES = 10;
	// receiver hold-off long enough to fill both pipeline stages many times over
	localparam int HOLD_CYCLES  = 300;
	// no beat may stay stuck longer than this; the hold-off is the longest legal stretch
	localparam int STUCK_LIMIT  = 3000;
	// covers the two register stages, with margin
	localparam int DRAIN_CYCLES = 8;
	// index past the register list; writes there must leave every register alone
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	logic                  start_req = 1'b0;
	logic                  full_cycle_mode = 1'b0;
	logic [DUTY_W-1:0]     duty_percent = '0;
	logic [SAMPLE_W-1:0]   current_sample = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	logic                  heater_on;
	logic                  busy_res;
	logic                  burst_done;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	int fault_cnt;
	int open_cnt;
	int checked_cnt;
	int done_cnt;

	// sender gap chance in percent, used only by the stimulus process
	int gap_pct = 0;
	// receiver stall chance in percent; written with nonblocking updates, read by the receiver
	int stall_pct = 0;
	// bumped once per requested hold-off; the receiver tracks its own copy
	int hold_req_cnt = 0;
	// current dead band, so samples can be aimed at its edges
	int zero_now = ZERO_OFFSET_RST;
	int band_now = CURRENT_BAND_RST;
	int settings_cnt = 1;
	int stuck_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	ac_heater_burst_driver_unit #(
		.CYCLES_PER_BURST(BURST_CYCLES)
	) uut (.*);

	heater_tick_checker #(
		.BURST_CYCLES(BURST_CYCLES)
	) scoreboard (.*);

	// Receiver: random stalls at the current rate, or a long hold-off when one is requested.
	// The request counter is read before this edge's updates land, so the hold starts
	// on a well-defined cycle.
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_req_cnt != hold_seen) begin
				hold_seen = hold_req_cnt;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Watchdog: count cycles in which neither channel moves a beat.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (res_valid && !res_stall)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles, %0d results still open",
				STUCK_LIMIT, open_cnt);
			$display("CHECK FAILED");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// Offer one tick beat, after random gaps, and hold it until the block takes it.
	// Valid stays high on return; the next call keeps it up or drops it.
	task automatic offer_tick(input logic start, input logic full,
			input logic [DUTY_W-1:0] duty, input logic [SAMPLE_W-1:0] sample);
		while ($urandom_range(99) < gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		start_req <= start;
		full_cycle_mode <= full;
		duty_percent <= duty;
		current_sample <= sample;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	// Drop valid, wait until every result is back, then load a new register set.
	// Upper data bits beyond each register's width are filled with noise.
	task automatic load_settings(input int zero, input int band, input int ticks);
		item_valid <= 1'b0;
		@(posedge clk);
		while (open_cnt != 0) @(posedge clk);
		write_reg(CFG_ZERO_OFFSET, {6'($urandom), 10'(zero)});
		write_reg(CFG_CURRENT_BAND, {6'($urandom), 10'(band)});
		write_reg(CFG_CYCLE_TICKS, 16'(ticks));
		write_reg(CFG_SPARE_IDX, 16'($urandom));
		cfg_we <= 1'b0;
		zero_now = zero;
		band_now = band;
		settings_cnt++;
	endtask

	// Aim roughly half the samples at the dead band and just past its edges.
	function automatic logic [SAMPLE_W-1:0] near_zero_sample();
		int lo;
		int hi;
		if ($urandom_range(99) < 45) begin
			lo = zero_now - band_now - 1;
			hi = zero_now + band_now + 1;
			if (lo < 0) lo = 0;
			if (hi > 1023) hi = 1023;
			return SAMPLE_W'($urandom_range(hi, lo));
		end
		return SAMPLE_W'($urandom_range(1023, 0));
	endfunction

	task automatic random_tick();
		logic              start;
		logic              full;
		logic [DUTY_W-1:0] duty;
		int                pick;
		start = ($urandom_range(5) == 0);
		full = 1'($urandom_range(1));
		pick = $urandom_range(99);
		if (pick < 12) duty = '0;
		else if (pick < 30) duty = DUTY_W'($urandom_range(255, 101));
		else duty = DUTY_W'($urandom_range(100, 1));
		offer_tick(start, full, duty, near_zero_sample());
	endtask

	task automatic random_stretch(input int zero, input int band, input int ticks,
			input int gap, input int stall, input int beats, input bit squeeze);
		load_settings(zero, band, ticks);
		gap_pct = gap;
		stall_pct <= stall;
		// ask for a long receiver hold while the sender keeps pushing
		if (squeeze) hold_req_cnt <= hold_req_cnt + 1;
		repeat (beats) random_tick();
	endtask

	// Hand-picked ticks: zero-duty start, dead-band edges, ignored starts while busy,
	// a register change mid-burst, cycle length zero, duty saturation, both modes.
	task automatic directed_ticks();
		// reset registers: zero at 419, band 2, long cycles
		offer_tick(1'b0, 1'b0, 8'd0, 10'd0);
		offer_tick(1'b1, 1'b1, 8'd0, 10'd1023);
		offer_tick(1'b1, 1'b1, 8'd50, 10'd419);
		offer_tick(1'b1, 1'b0, 8'd0, 10'd421);
		offer_tick(1'b0, 1'b1, 8'd50, 10'd417);
		offer_tick(1'b0, 1'b1, 8'd50, 10'd422);
		offer_tick(1'b0, 1'b1, 8'd50, 10'd419);
		// shrink the cycle to zero ticks while the burst runs: every tick ends a cycle
		load_settings(500, 3, 0);
		repeat (BURST_CYCLES) offer_tick(1'b1, 1'b1, 8'd0, 10'd500);
		// dimmer start with duty above 100, current already flowing
		offer_tick(1'b1, 1'b0, 8'd255, 10'd1023);
		repeat (BURST_CYCLES) offer_tick(1'b0, 1'b0, 8'd0, 10'd0);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_ticks();

		random_stretch(500, 3, 4, 0, 0, 180, 1'b0);
		random_stretch(0, 0, 1, 68, 0, 100, 1'b0);
		random_stretch(1023, 5, 7, 0, 68, 100, 1'b0);
		random_stretch(419, 2, 3, 30, 30, 100, 1'b0);
		// widest band: current never counts, the block parks in its wait state
		random_stretch(300, 1023, 2, 0, 0, 30, 1'b0);
		random_stretch(600, 10, 65535, 30, 30, 40, 1'b0);
		random_stretch(512, 1, 2, 0, 0, 80, 1'b1);
		random_stretch(700, 4, 5, 68, 68, 120, 1'b0);
		random_stretch(100, 2, 1, 0, 0, 110, 1'b0);

		// drain: wait out every open result, then the drain margin for strays
		item_valid <= 1'b0;
		@(posedge clk);
		while (open_cnt != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d tick beats across %0d register sets; %0d bursts or zero-duty starts ended.",
			checked_cnt, settings_cnt, done_cnt);
		$display("Traffic mixed free flow, sender gaps, receiver stalls, both, and one long hold; %0d mismatches.",
			fault_cnt);
		if (fault_cnt == 0 && open_cnt == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
